>>> rtl/pqa_pkg.sv
// Shared constants, codes and types for the aging priority queue.
// Used by the channel interfaces, the controller, the datapath and the top level.
// No dependencies.
package pqa_pkg;

    // Queue size and derived widths
    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int HELD_W      = $clog2(QUEUE_DEPTH + 1);

    // Field widths
    localparam int OP_W     = 2;
    localparam int DATA_W   = 32;
    localparam int PRIO_W   = 11;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;
    localparam int STAMP_W  = 16;

    localparam logic [PRIO_W-1:0] AGING_LIMIT_RESET = PRIO_W'(1024);

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_AGE    = 2'd2,
        OP_NOP    = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // One stored entry
    typedef struct packed {
        logic signed [DATA_W-1:0] data;
        logic [PRIO_W-1:0]        orig;
        logic [PRIO_W-1:0]        cur;
        logic [STAMP_W-1:0]       stamp;
    } slot_t;

    localparam int SLOT_W = $bits(slot_t);

    // Controller to datapath
    typedef struct packed {
        logic capture;    // latch the input item, reset the scan
        logic scan_read;  // read the slot at the scan index, advance it
        logic finish;     // commit the operation, load the result
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic scan_last;  // scan index is at the last slot
        logic out_free;   // result register can take a new result
    } ctrl_stat_t;

endpackage

>>> rtl/pqa_in_if.sv
// Input channel of the aging priority queue: valid/ready plus one operation.
// Depends on pqa_pkg.
interface pqa_in_if;
    logic                             valid;
    logic                             ready;
    logic [pqa_pkg::OP_W-1:0]         operation;
    logic signed [pqa_pkg::DATA_W-1:0] item_data;
    logic [pqa_pkg::PRIO_W-1:0]       priority_req;
    logic [pqa_pkg::PRIO_W-1:0]       age_amount;

    modport source (
        output valid, operation, item_data, priority_req, age_amount,
        input  ready
    );
    modport sink (
        input  valid, operation, item_data, priority_req, age_amount,
        output ready
    );
endinterface

>>> rtl/pqa_out_if.sv
// Result channel of the aging priority queue: valid/ready plus one result.
// Depends on pqa_pkg.
interface pqa_out_if;
    logic                              valid;
    logic                              ready;
    logic [pqa_pkg::STATUS_W-1:0]      status;
    logic signed [pqa_pkg::DATA_W-1:0] out_data;
    logic [pqa_pkg::PRIO_W-1:0]        out_priority;
    logic [pqa_pkg::COUNT_W-1:0]       entry_count;

    modport source (
        output valid, status, out_data, out_priority, entry_count,
        input  ready
    );
    modport sink (
        input  valid, status, out_data, out_priority, entry_count,
        output ready
    );
endinterface

>>> rtl/pqa_ram.sv
// Generic RAM: one write port, one read port, registered read data.
// No dependencies.
module pqa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                         clk,
    input  logic                                         we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                             wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                             rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rd_data_reg <= mem_reg[raddr];
    end

    assign rdata = rd_data_reg;

endmodule

>>> rtl/pqa_ctrl.sv
// Controller of the aging priority queue: sequences capture, slot scan and commit.
// Depends on pqa_pkg; drives the datapath through ctrl_cmd_t.
module pqa_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  pqa_pkg::op_t        in_op,
    output logic                in_ready,
    input  pqa_pkg::ctrl_stat_t stat,
    output pqa_pkg::ctrl_cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_DRAIN = 4'b0100,
        S_DONE  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    if (in_op inside {pqa_pkg::OP_REMOVE, pqa_pkg::OP_AGE})
                    begin
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_SCAN:
            begin
                cmd.scan_read = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            // last read slot is evaluated here
            S_DRAIN:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> rtl/pqa_dp.sv
// Datapath of the aging priority queue: slot RAM, valid bits, scan/compare logic,
// aging write-back and the result register. Depends on pqa_pkg and pqa_ram.
module pqa_dp (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  pqa_pkg::ctrl_cmd_t                    cmd,
    output pqa_pkg::ctrl_stat_t                   stat,
    input  logic                                  cfg_we,
    input  logic [pqa_pkg::PRIO_W-1:0]            cfg_data,
    input  logic [pqa_pkg::OP_W-1:0]              in_operation,
    input  logic signed [pqa_pkg::DATA_W-1:0]     in_item_data,
    input  logic [pqa_pkg::PRIO_W-1:0]            in_priority_req,
    input  logic [pqa_pkg::PRIO_W-1:0]            in_age_amount,
    input  logic                                  out_ready,
    output logic                                  out_valid,
    output logic [pqa_pkg::STATUS_W-1:0]          out_status,
    output logic signed [pqa_pkg::DATA_W-1:0]     out_data,
    output logic [pqa_pkg::PRIO_W-1:0]            out_priority,
    output logic [pqa_pkg::COUNT_W-1:0]           out_entry_count
);

    // Captured item and configuration
    pqa_pkg::op_t                       op_reg;
    logic signed [pqa_pkg::DATA_W-1:0]  data_reg;
    logic [pqa_pkg::PRIO_W-1:0]         prio_reg;
    logic [pqa_pkg::PRIO_W-1:0]         amount_reg;
    logic [pqa_pkg::PRIO_W-1:0]         limit_reg;

    // Queue bookkeeping
    logic [pqa_pkg::QUEUE_DEPTH-1:0]    valid_reg;
    logic [pqa_pkg::HELD_W-1:0]         held_reg;
    logic [pqa_pkg::STAMP_W-1:0]        arrival_reg;

    // Scan pipeline
    logic [pqa_pkg::IDX_W-1:0]          idx_reg;
    logic                               proc_valid_reg;
    logic [pqa_pkg::IDX_W-1:0]          proc_idx_reg;

    // Best candidate of a remove scan
    logic                               best_found_reg;
    logic [pqa_pkg::IDX_W-1:0]          best_idx_reg;
    logic [pqa_pkg::PRIO_W-1:0]         best_cur_reg;
    logic [pqa_pkg::STAMP_W-1:0]        best_age_reg;
    logic signed [pqa_pkg::DATA_W-1:0]  best_data_reg;
    logic [pqa_pkg::PRIO_W-1:0]         best_orig_reg;

    // Result register
    logic                               out_valid_reg;
    pqa_pkg::status_t                   out_status_reg;
    logic signed [pqa_pkg::DATA_W-1:0]  out_data_reg;
    logic [pqa_pkg::PRIO_W-1:0]         out_prio_reg;
    logic [pqa_pkg::HELD_W-1:0]         out_count_reg;

    // RAM ports
    logic                               ram_we;
    logic [pqa_pkg::IDX_W-1:0]          ram_waddr;
    pqa_pkg::slot_t                     ram_wdata;
    pqa_pkg::slot_t                     rd_slot;

    // Combinational helpers
    logic [pqa_pkg::IDX_W-1:0]          free_idx;
    logic                               full;
    logic                               proc_hit;
    logic [pqa_pkg::PRIO_W:0]           age_sum;
    logic                               age_fits;
    logic [pqa_pkg::STAMP_W-1:0]        rd_age;
    logic                               better;
    logic                               do_insert;
    logic                               do_remove;

    pqa_ram #(
        .WIDTH (pqa_pkg::SLOT_W),
        .DEPTH (pqa_pkg::QUEUE_DEPTH)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (idx_reg),
        .rdata (rd_slot)
    );

    // Lowest free slot
    always_comb
    begin
        free_idx = '0;
        for (int i = pqa_pkg::QUEUE_DEPTH - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_idx = pqa_pkg::IDX_W'(i);
            end
        end
    end

    assign full      = (held_reg == pqa_pkg::HELD_W'(pqa_pkg::QUEUE_DEPTH));
    assign do_insert = cmd.finish && (op_reg == pqa_pkg::OP_INSERT) && !full;
    assign do_remove = cmd.finish && (op_reg == pqa_pkg::OP_REMOVE) && best_found_reg;

    // Evaluate the slot whose read data just arrived
    assign proc_hit = proc_valid_reg && valid_reg[proc_idx_reg];
    assign age_sum  = {1'b0, rd_slot.cur} + {1'b0, amount_reg};
    assign age_fits = (age_sum <= {1'b0, limit_reg});
    assign rd_age   = arrival_reg - rd_slot.stamp;
    assign better   = !best_found_reg || (rd_slot.cur > best_cur_reg) ||
                      ((rd_slot.cur == best_cur_reg) && (rd_age > best_age_reg));

    // RAM write: insert at commit, aging write-back during the scan
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = proc_idx_reg;
        ram_wdata = rd_slot;
        if (do_insert)
        begin
            ram_we          = 1'b1;
            ram_waddr       = free_idx;
            ram_wdata.data  = data_reg;
            ram_wdata.orig  = prio_reg;
            ram_wdata.cur   = prio_reg;
            ram_wdata.stamp = arrival_reg;
        end
        else if (proc_hit && (op_reg == pqa_pkg::OP_AGE) && age_fits)
        begin
            ram_we        = 1'b1;
            ram_wdata.cur = age_sum[pqa_pkg::PRIO_W-1:0];
        end
    end

    // Captured item
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            data_reg   <= in_item_data;
            prio_reg   <= in_priority_req;
            amount_reg <= in_age_amount;
        end
    end

    // Best candidate payload
    always_ff @(posedge clk)
    begin
        if (proc_hit && (op_reg == pqa_pkg::OP_REMOVE) && better)
        begin
            best_idx_reg  <= proc_idx_reg;
            best_cur_reg  <= rd_slot.cur;
            best_age_reg  <= rd_age;
            best_data_reg <= rd_slot.data;
            best_orig_reg <= rd_slot.orig;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_status_reg <= pqa_pkg::ST_OK;
            out_data_reg   <= '0;
            out_prio_reg   <= '0;
            out_count_reg  <= held_reg;
            case (op_reg)
                pqa_pkg::OP_INSERT:
                begin
                    if (full)
                    begin
                        out_status_reg <= pqa_pkg::ST_FULL;
                    end
                    else
                    begin
                        out_count_reg <= held_reg + 1'b1;
                    end
                end
                pqa_pkg::OP_REMOVE:
                begin
                    if (best_found_reg)
                    begin
                        out_data_reg  <= best_data_reg;
                        out_prio_reg  <= best_orig_reg;
                        out_count_reg <= held_reg - 1'b1;
                    end
                    else
                    begin
                        out_status_reg <= pqa_pkg::ST_EMPTY;
                    end
                end
                default:
                begin
                    out_status_reg <= pqa_pkg::ST_OK;
                end
            endcase
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg         <= pqa_pkg::OP_NOP;
            limit_reg      <= pqa_pkg::AGING_LIMIT_RESET;
            valid_reg      <= '0;
            held_reg       <= '0;
            arrival_reg    <= '0;
            idx_reg        <= '0;
            proc_valid_reg <= 1'b0;
            proc_idx_reg   <= '0;
            best_found_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                limit_reg <= cfg_data;
            end

            // scan index and read pipeline
            proc_valid_reg <= cmd.scan_read;
            proc_idx_reg   <= idx_reg;
            if (cmd.capture)
            begin
                op_reg         <= pqa_pkg::op_t'(in_operation);
                idx_reg        <= '0;
                best_found_reg <= 1'b0;
            end
            else if (cmd.scan_read)
            begin
                idx_reg <= idx_reg + 1'b1;
            end

            if (proc_hit && (op_reg == pqa_pkg::OP_REMOVE) && better)
            begin
                best_found_reg <= 1'b1;
            end

            // commit
            if (do_insert)
            begin
                valid_reg[free_idx] <= 1'b1;
                held_reg            <= held_reg + 1'b1;
                arrival_reg         <= arrival_reg + 1'b1;
            end
            else if (do_remove)
            begin
                valid_reg[best_idx_reg] <= 1'b0;
                held_reg                <= held_reg - 1'b1;
            end

            // result handshake
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.scan_last = (idx_reg == pqa_pkg::IDX_W'(pqa_pkg::QUEUE_DEPTH - 1));
    assign stat.out_free  = !out_valid_reg || out_ready;

    assign out_valid       = out_valid_reg;
    assign out_status      = out_status_reg;
    assign out_data        = out_data_reg;
    assign out_priority    = out_prio_reg;
    assign out_entry_count = pqa_pkg::COUNT_W'(out_count_reg);

`ifndef SYNTHESIS
    // count matches the valid bits
    a_count_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == held_reg)
        else $error("held count differs from number of valid slots");

    // never more entries than slots
    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= pqa_pkg::HELD_W'(pqa_pkg::QUEUE_DEPTH))
        else $error("held count above queue depth");

    // aging writes only touch held slots
    a_age_write_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && !do_insert) |-> valid_reg[ram_waddr])
        else $error("aging write-back to a free slot");

    // removed slot is freed
    a_remove_frees: assert property (@(posedge clk) disable iff (!rst_n)
        do_remove |=> !valid_reg[$past(best_idx_reg)])
        else $error("removed slot still marked valid");

    // result only loaded into a free result register
    a_finish_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> stat.out_free)
        else $error("result overwritten before transfer");
`endif

endmodule

>>> rtl/priority_queue_with_aging_core.sv
// Aging priority queue, top level: controller plus datapath on two channels.
// Depends on pqa_pkg, pqa_in_if, pqa_out_if, pqa_ctrl, pqa_dp (pqa_ram).
//
// Usage:
//   in_ch  carries one operation per transfer: insert (item_data, priority_req),
//          remove highest current priority, age by age_amount (within aging_limit), or nop.
//   out_ch returns exactly one result per operation: status, removed data and
//          original priority (zero otherwise) and the entry count afterwards.
//   cfg_we/cfg_data write aging_limit; write it only while the block is idle.
// Sequence:
//   Insert and nop go from the input transfer straight to the commit, which loads
//   the result register once it is free; the next input is taken after the commit.
//   Remove and age scan all slots, evaluate the last read slot, then commit; the
//   slot RAM is read one slot per cycle, with aging write-back on its write port.
//   One operation is worked on at a time; in_ch.ready is high only between
//   operations, including while a finished result waits on out_ch.
// Reset: queue empty, arrival counter zero, aging_limit 1024.
// Stall: when out_ch.ready is low the result holds; a following operation is
//   taken and processed, then waits for the result register to drain.
module priority_queue_with_aging_core (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [pqa_pkg::PRIO_W-1:0] cfg_data,
    pqa_in_if.sink                     in_ch,
    pqa_out_if.source                  out_ch
);

    pqa_pkg::ctrl_cmd_t  cmd;
    pqa_pkg::ctrl_stat_t stat;
    logic                ctrl_ready;

    pqa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_op    (pqa_pkg::op_t'(in_ch.operation)),
        .in_ready (ctrl_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    pqa_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .cfg_we          (cfg_we),
        .cfg_data        (cfg_data),
        .in_operation    (in_ch.operation),
        .in_item_data    (in_ch.item_data),
        .in_priority_req (in_ch.priority_req),
        .in_age_amount   (in_ch.age_amount),
        .out_ready       (out_ch.ready),
        .out_valid       (out_ch.valid),
        .out_status      (out_ch.status),
        .out_data        (out_ch.out_data),
        .out_priority    (out_ch.out_priority),
        .out_entry_count (out_ch.entry_count)
    );

    assign in_ch.ready = ctrl_ready;

endmodule

>>> bench/pqa_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the aging priority queue: watches both channels and the config port,
// predicts each result and compares it field by field.
// Depends on pqa_pkg, pqa_in_if and pqa_out_if.
module pqa_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [pqa_pkg::PRIO_W-1:0] cfg_data,
    pqa_in_if                          in_mon,
    pqa_out_if                         out_mon,
    output int                         fail_count,
    output int                         outstanding
);
    import pqa_pkg::*;

    typedef struct packed {
        status_t                  status;
        logic signed [DATA_W-1:0] data;
        logic [PRIO_W-1:0]        prio;
        logic [COUNT_W-1:0]       count;
    } queue_result_t;

    // Shadow copy of the queue contents
    logic signed [DATA_W-1:0] slot_word  [QUEUE_DEPTH];
    logic [PRIO_W-1:0]        slot_orig  [QUEUE_DEPTH];
    logic [PRIO_W-1:0]        slot_cur   [QUEUE_DEPTH];
    logic [STAMP_W-1:0]       slot_stamp [QUEUE_DEPTH];
    logic                     slot_busy  [QUEUE_DEPTH];
    int                       held;
    logic [STAMP_W-1:0]       next_stamp;
    logic [PRIO_W-1:0]        limit_reg;

    queue_result_t pending_results[$];
    queue_result_t want;
    int            new_failures;

    // Applies one operation to the shadow queue and returns the result it must produce
    function automatic queue_result_t predict_queue_result(
        op_t                      op,
        logic signed [DATA_W-1:0] word,
        logic [PRIO_W-1:0]        prio,
        logic [PRIO_W-1:0]        amount
    );
        queue_result_t      res;
        int                 pick;
        logic [PRIO_W-1:0]  pick_prio;
        logic [STAMP_W-1:0] pick_age;
        logic [STAMP_W-1:0] slot_age;
        logic [PRIO_W:0]    raised;
        res       = '0;
        res.status = ST_OK;
        pick      = -1;
        pick_prio = '0;
        pick_age  = '0;
        case (op)
            OP_INSERT:
            begin
                // lowest free slot
                for (int i = 0; i < QUEUE_DEPTH; i++)
                    if (!slot_busy[i] && pick < 0)
                        pick = i;
                if (pick < 0)
                    res.status = ST_FULL;
                else
                begin
                    slot_busy[pick]  = 1'b1;
                    slot_word[pick]  = word;
                    slot_orig[pick]  = prio;
                    slot_cur[pick]   = prio;
                    slot_stamp[pick] = next_stamp;
                    next_stamp       = next_stamp + 1'b1;
                    held++;
                end
            end
            OP_REMOVE:
            begin
                // highest current priority; oldest wins a tie, lowest slot on equal age
                for (int i = 0; i < QUEUE_DEPTH; i++)
                begin
                    if (slot_busy[i])
                    begin
                        slot_age = next_stamp - slot_stamp[i];
                        if (pick < 0 || slot_cur[i] > pick_prio ||
                            (slot_cur[i] == pick_prio && slot_age > pick_age))
                        begin
                            pick      = i;
                            pick_prio = slot_cur[i];
                            pick_age  = slot_age;
                        end
                    end
                end
                if (pick < 0)
                    res.status = ST_EMPTY;
                else
                begin
                    res.data        = slot_word[pick];
                    res.prio        = slot_orig[pick];
                    slot_busy[pick] = 1'b0;
                    held--;
                end
            end
            OP_AGE:
            begin
                // raise only where the sum stays within the limit
                for (int i = 0; i < QUEUE_DEPTH; i++)
                begin
                    if (slot_busy[i])
                    begin
                        raised = {1'b0, slot_cur[i]} + {1'b0, amount};
                        if (raised <= {1'b0, limit_reg})
                            slot_cur[i] = raised[PRIO_W-1:0];
                    end
                end
            end
            default: ;
        endcase
        res.count = COUNT_W'(held);
        return res;
    endfunction

    // Predict on input transfers, compare on output transfers
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < QUEUE_DEPTH; i++)
                slot_busy[i] = 1'b0;
            held       = 0;
            next_stamp = '0;
            limit_reg  = AGING_LIMIT_RESET;
            pending_results.delete();
            fail_count  <= 0;
            outstanding <= 0;
        end
        else
        begin
            new_failures = 0;
            if (cfg_we)
                limit_reg = cfg_data;
            if (in_mon.valid && in_mon.ready)
                pending_results.push_back(predict_queue_result(op_t'(in_mon.operation),
                    in_mon.item_data, in_mon.priority_req, in_mon.age_amount));
            if (out_mon.valid && out_mon.ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result transfer with no operation outstanding");
                    new_failures++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (out_mon.status !== want.status)
                    begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, out_mon.status);
                        new_failures++;
                    end
                    if (out_mon.out_data !== want.data)
                    begin
                        $error("out_data mismatch: expected %0d, actual %0d",
                               want.data, out_mon.out_data);
                        new_failures++;
                    end
                    if (out_mon.out_priority !== want.prio)
                    begin
                        $error("out_priority mismatch: expected %0d, actual %0d",
                               want.prio, out_mon.out_priority);
                        new_failures++;
                    end
                    if (out_mon.entry_count !== want.count)
                    begin
                        $error("entry_count mismatch: expected %0d, actual %0d",
                               want.count, out_mon.entry_count);
                        new_failures++;
                    end
                end
            end
            fail_count  <= fail_count + new_failures;
            outstanding <= pending_results.size();
        end
    end

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps
// Top of the aging priority queue bench: clock, reset, stimulus, receiver and verdict.
// Depends on pqa_pkg, pqa_in_if, pqa_out_if, pqa_checker and priority_queue_with_aging_core.
module testbench;
    import pqa_pkg::*;

    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 8;
    localparam int PHASE_ITEMS  = 445;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 24;
    localparam int CYCLE_LIMIT  = 400000;

    // Priorities used to fill the queue in the directed part: extremes, ties, near the limit
    localparam logic [PRIO_W-1:0] FILL_PRIOS [QUEUE_DEPTH] = '{
        11'd2047, 11'd0, 11'd1024, 11'd1023, 11'd7, 11'd7, 11'd7, 11'd1020,
        11'd2047, 11'd1, 11'd1024, 11'd512, 11'd1025, 11'd3, 11'd1000, 11'd7
    };

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [PRIO_W-1:0] cfg_data;
    logic              hold_off_req;
    int                fail_count;
    int                outstanding;
    int                idle_pct;
    int                stall_pct;
    int                cycle_count;
    int                queue_fill;
    bit                draining;
    logic [PRIO_W-1:0] limit_now;

    pqa_in_if  in_ch ();
    pqa_out_if out_ch ();

    priority_queue_with_aging_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .in_ch    (in_ch),
        .out_ch   (out_ch)
    );

    pqa_checker scoreboard (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .in_mon      (in_ch),
        .out_mon     (out_ch),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Watchdog
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Regression FAIL");
        $finish;
    end

    // Result receiver: random stalls, plus one long hold-off on request
    initial
    begin
        int hold_left;
        bit hold_taken;
        hold_left  = 0;
        hold_taken = 1'b0;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req && !hold_taken)
            begin
                hold_taken = 1'b1;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end
            else
                out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // One operation on the input channel, after a random idle gap
    task automatic send_op(op_t op, logic [DATA_W-1:0] word, logic [PRIO_W-1:0] prio,
                           logic [PRIO_W-1:0] amount);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.operation    <= op;
        in_ch.item_data    <= word;
        in_ch.priority_req <= prio;
        in_ch.age_amount   <= amount;
        do
            @(posedge clk);
        while (!in_ch.ready);
        if (op == OP_INSERT && queue_fill < QUEUE_DEPTH)
            queue_fill++;
        else if (op == OP_REMOVE && queue_fill > 0)
            queue_fill--;
    endtask

    // Random operation; swings between filling and draining so full and empty both recur
    task automatic send_random();
        int                pick;
        int                lo;
        int                hi;
        op_t               op;
        logic [PRIO_W-1:0] prio;
        logic [PRIO_W-1:0] amount;
        if (queue_fill == QUEUE_DEPTH)
            draining = 1'b1;
        else if (queue_fill == 0)
            draining = 1'b0;
        pick = $urandom_range(0, 99);
        if (pick < 3)
            op = OP_NOP;
        else if (pick < 15)
            op = OP_AGE;
        else if (pick < (draining ? 40 : 78))
            op = OP_INSERT;
        else
            op = OP_REMOVE;
        // priorities: narrow band for ties, a band around the limit, or anything
        lo = (int'(limit_now) > 8) ? int'(limit_now) - 8 : 0;
        hi = (int'(limit_now) + 8 > 2047) ? 2047 : int'(limit_now) + 8;
        case ($urandom_range(0, 4))
            0, 1:    prio = PRIO_W'($urandom_range(0, 7));
            2:       prio = PRIO_W'($urandom_range(hi, lo));
            default: prio = PRIO_W'($urandom_range(0, 2047));
        endcase
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: amount = PRIO_W'($urandom_range(0, 7));
            5, 6, 7:       amount = PRIO_W'($urandom_range(0, 255));
            default:       amount = PRIO_W'($urandom_range(0, 2047));
        endcase
        send_op(op, $urandom, prio, amount);
    endtask

    // Wait until every result has been taken and the block has settled
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_aging_limit(logic [PRIO_W-1:0] value);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_data  <= value;
        limit_now = value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Empty-queue cases, fill to full, overfill, aging across the limit, tie order
    task automatic run_directed();
        logic [DATA_W-1:0] word;
        send_op(OP_REMOVE, $urandom, PRIO_W'($urandom), PRIO_W'($urandom));
        send_op(OP_AGE, $urandom, PRIO_W'($urandom), 11'd5);
        send_op(OP_NOP, $urandom, PRIO_W'($urandom), PRIO_W'($urandom));
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            case (i)
                0:       word = 32'h7FFF_FFFF;
                1:       word = 32'h8000_0000;
                2:       word = 32'h0000_0000;
                3:       word = 32'hFFFF_FFFF;
                default: word = $urandom;
            endcase
            send_op(OP_INSERT, word, FILL_PRIOS[i], '0);
        end
        send_op(OP_INSERT, $urandom, 11'd2047, '0);
        send_op(OP_AGE, $urandom, '0, 11'd3);
        send_op(OP_AGE, $urandom, '0, 11'd2047);
        send_op(OP_AGE, $urandom, '0, 11'd0);
        repeat (3) send_op(OP_REMOVE, $urandom, '0, '0);
    endtask

    task automatic run_phase(int idle, int stall, logic [PRIO_W-1:0] limit, bit with_hold);
        set_aging_limit(limit);
        idle_pct = idle;
        stall_pct <= stall;
        for (int n = 0; n < PHASE_ITEMS; n++)
        begin
            if (with_hold && n == 40)
                hold_off_req <= 1'b1;
            send_random();
        end
    endtask

    // Stimulus and verdict
    initial
    begin
        rst_n              <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_data           <= '0;
        hold_off_req       <= 1'b0;
        stall_pct          <= 0;
        in_ch.valid        <= 1'b0;
        in_ch.operation    <= OP_NOP;
        in_ch.item_data    <= '0;
        in_ch.priority_req <= '0;
        in_ch.age_amount   <= '0;
        idle_pct   = 0;
        queue_fill = 0;
        draining   = 1'b0;
        limit_now  = AGING_LIMIT_RESET;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        run_phase(0, 0, 11'd2047, 1'b1);
        run_phase(49, 0, 11'd0, 1'b0);
        run_phase(0, 49, PRIO_W'($urandom_range(1, 2046)), 1'b0);
        run_phase(9, 9, AGING_LIMIT_RESET, 1'b0);
        wait_idle();

        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

>>> filelist.f
rtl/pqa_pkg.sv
rtl/pqa_in_if.sv
rtl/pqa_out_if.sv
rtl/pqa_ram.sv
rtl/pqa_ctrl.sv
rtl/pqa_dp.sv
rtl/priority_queue_with_aging_core.sv
bench/pqa_checker.sv
bench/testbench.sv
